// ===== hdl/json_string_escaper_utf8_check_macros.svh =====
// Assertion macros for the JSON string escaper.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_MACROS_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_MACROS_SVH

// Checks an implication in the same cycle, disabled during reset.
`define JSEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the following cycle, disabled during reset.
`define JSEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jseu_pkg.sv =====
// Package for the JSON string escaper: character codes, UTF-8 limits and types.
// No dependencies.
package jseu_pkg;

  localparam logic [15:0] CAP_RESET   = 16'd8190;
  localparam int          MAX_RESULTS = 7;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UTF8     = 2'd1,
    ERR_CAPACITY = 2'd2
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_LOW  = 8'h61;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] ASCII_END = 8'h80;

  localparam logic [20:0] MIN_CP3 = 21'h000800;
  localparam logic [20:0] SUR_LO  = 21'h00D800;
  localparam logic [20:0] SUR_HI  = 21'h00DFFF;
  localparam logic [20:0] MIN_CP4 = 21'h010000;
  localparam logic [20:0] MAX_CP  = 21'h10FFFF;

  typedef logic [7:0] piece_buf_t [0:MAX_RESULTS-1];

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_A_LOW + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== hdl/json_string_escaper_utf8_check.sv =====
// JSON string escaper with strict UTF-8 check: top level, one module.
// Depends on jseu_pkg and json_string_escaper_utf8_check_macros.svh.
//
//  channel  signals                              direction  request
//  in       in_valid/in_ready                    to block   data_byte, string_end
//  out      out_valid/out_ready                  from block out_byte, has_byte, last, status
//  cfg      cfg_valid/cfg_ready                  to block   cfg_data (output_capacity)
//
// An accepted request is escaped and checked in the cycle it is taken; its zero to seven
// results go into a result buffer that drains one per cycle while out_ready is high.
// A byte that yields at most one result keeps the rate at one request per cycle while out_ready
// is high; an escape of n results holds the input until the buffer hands over its final result.
// Reset (rst, synchronous) clears the per-string state and sets the capacity to 8190.
// Input is taken while the buffer is empty or hands over its final result in that cycle.
`include "json_string_escaper_utf8_check_macros.svh"

module json_string_escaper_utf8_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        last,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import jseu_pkg::*;

  logic [15:0] output_capacity;
  logic        quote_opened;
  logic [1:0]  continuation_left;
  logic [1:0]  sequence_length;
  logic [20:0] code_point_acc;
  logic [15:0] bytes_emitted;
  err_t        error_kind;

  piece_buf_t  pieces;
  logic [2:0]  count;
  logic [2:0]  rd;
  logic        fin_has;
  logic        fin_last;
  err_t        fin_status;

  logic        quote_opened_next;
  logic [1:0]  continuation_left_next;
  logic [1:0]  sequence_length_next;
  logic [20:0] code_point_acc_next;
  logic [15:0] bytes_emitted_next;
  err_t        error_kind_next;
  piece_buf_t  pieces_next;
  logic [2:0]  count_next;
  logic        fin_has_next;
  logic        fin_last_next;
  err_t        fin_status_next;

  logic        in_fire;
  logic        out_fire;
  logic        at_final;
  logic        string_cleared;
  logic        utf8_drop;

  assign cfg_ready = 1'b1;
  assign out_valid = (count != 3'd0);
  assign at_final  = (rd == count - 3'd1);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (count == 3'd0) || (out_ready && at_final);
  assign in_fire   = in_valid && in_ready;

  assign out_byte = pieces[rd];
  assign has_byte = at_final ? fin_has : 1'b1;
  assign last     = at_final && fin_last;
  assign status   = last ? fin_status : ERR_NONE;

  assign string_cleared = !quote_opened && (bytes_emitted == 16'd0) &&
                          (error_kind == ERR_NONE);
  assign utf8_drop      = in_fire && !string_end && (error_kind == ERR_UTF8);

  always_comb begin
    logic [16:0] cap17;
    logic [16:0] be;
    logic [7:0]  esc;
    logic        utf_ok;
    logic        done;
    logic [2:0]  k;
    err_t        ek;
    cap17 = {1'b0, output_capacity};
    be    = {1'b0, bytes_emitted};
    ek    = error_kind;
    quote_opened_next      = quote_opened;
    continuation_left_next = continuation_left;
    sequence_length_next   = sequence_length;
    code_point_acc_next    = code_point_acc;
    pieces_next = '{default: 8'h00};
    k        = 3'd0;
    esc      = 8'h00;
    utf_ok   = 1'b1;
    done     = 1'b0;
    fin_has_next  = 1'b1;
    fin_last_next = 1'b0;

    if (string_end) begin
      fin_last_next = 1'b1;
      if (ek != ERR_UTF8 && continuation_left != 2'd0) begin
        ek = ERR_UTF8;
      end
      if (ek == ERR_NONE) begin
        if (!quote_opened) begin
          if (be + 17'd1 <= cap17) begin
            pieces_next[k] = CH_QUOTE;
            k  = k + 3'd1;
            be = be + 17'd1;
          end else begin
            ek = ERR_CAPACITY;
          end
        end
        if (ek == ERR_NONE) begin
          if (be + 17'd1 <= cap17) begin
            pieces_next[k] = CH_QUOTE;
            k    = k + 3'd1;
            done = 1'b1;
          end else begin
            ek = ERR_CAPACITY;
          end
        end
      end
      if (!done) begin
        pieces_next[k] = 8'h00;
        k = k + 3'd1;
        fin_has_next = 1'b0;
      end
      fin_status_next        = ek;
      quote_opened_next      = 1'b0;
      continuation_left_next = 2'd0;
      sequence_length_next   = 2'd0;
      code_point_acc_next    = 21'd0;
      be                     = 17'd0;
      ek                     = ERR_NONE;
    end else begin
      fin_status_next = ERR_NONE;
      if (ek != ERR_UTF8) begin
        if (continuation_left == 2'd0) begin
          if (data_byte < ASCII_END) begin
            utf_ok = 1'b1;
          end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            sequence_length_next   = 2'd1;
            continuation_left_next = 2'd1;
            code_point_acc_next    = {16'd0, data_byte[4:0]};
          end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            sequence_length_next   = 2'd2;
            continuation_left_next = 2'd2;
            code_point_acc_next    = {17'd0, data_byte[3:0]};
          end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            sequence_length_next   = 2'd3;
            continuation_left_next = 2'd3;
            code_point_acc_next    = {18'd0, data_byte[2:0]};
          end else begin
            utf_ok = 1'b0;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          utf_ok = 1'b0;
        end else begin
          code_point_acc_next    = {code_point_acc[14:0], data_byte[5:0]};
          continuation_left_next = continuation_left - 2'd1;
          if (continuation_left_next == 2'd0) begin
            if (sequence_length == 2'd2 &&
                (code_point_acc_next < MIN_CP3 ||
                 (code_point_acc_next >= SUR_LO && code_point_acc_next <= SUR_HI))) begin
              utf_ok = 1'b0;
            end
            if (sequence_length == 2'd3 &&
                (code_point_acc_next < MIN_CP4 || code_point_acc_next > MAX_CP)) begin
              utf_ok = 1'b0;
            end
          end
        end

        if (!utf_ok) begin
          ek = ERR_UTF8;
        end else if (ek == ERR_NONE) begin
          if (!quote_opened) begin
            if (be + 17'd1 <= cap17) begin
              pieces_next[k] = CH_QUOTE;
              k  = k + 3'd1;
              be = be + 17'd1;
              quote_opened_next = 1'b1;
            end else begin
              ek = ERR_CAPACITY;
            end
          end
          if (ek == ERR_NONE) begin
            case (data_byte)
              CH_QUOTE:  esc = CH_QUOTE;
              CH_BSLASH: esc = CH_BSLASH;
              CH_LF:     esc = CH_N;
              CH_CR:     esc = CH_R;
              CH_TAB:    esc = CH_T;
              default:   esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
              if (be + 17'd2 <= cap17) begin
                pieces_next[k]        = CH_BSLASH;
                pieces_next[k + 3'd1] = esc;
                k  = k + 3'd2;
                be = be + 17'd2;
              end else begin
                ek = ERR_CAPACITY;
              end
            end else if (data_byte <= CTRL_MAX) begin
              if (be + 17'd6 <= cap17) begin
                pieces_next[k]        = CH_BSLASH;
                pieces_next[k + 3'd1] = CH_U;
                pieces_next[k + 3'd2] = CH_ZERO;
                pieces_next[k + 3'd3] = CH_ZERO;
                pieces_next[k + 3'd4] = hex_lower(data_byte[7:4]);
                pieces_next[k + 3'd5] = hex_lower(data_byte[3:0]);
                k  = k + 3'd6;
                be = be + 17'd6;
              end else begin
                ek = ERR_CAPACITY;
              end
            end else begin
              if (be + 17'd1 <= cap17) begin
                pieces_next[k] = data_byte;
                k  = k + 3'd1;
                be = be + 17'd1;
              end else begin
                ek = ERR_CAPACITY;
              end
            end
          end
        end
      end
    end
    count_next         = k;
    bytes_emitted_next = be[15:0];
    error_kind_next    = ek;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      output_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_opened      <= 1'b0;
      continuation_left <= 2'd0;
      sequence_length   <= 2'd0;
      code_point_acc    <= 21'd0;
      bytes_emitted     <= 16'd0;
      error_kind        <= ERR_NONE;
    end else if (in_fire) begin
      quote_opened      <= quote_opened_next;
      continuation_left <= continuation_left_next;
      sequence_length   <= sequence_length_next;
      code_point_acc    <= code_point_acc_next;
      bytes_emitted     <= bytes_emitted_next;
      error_kind        <= error_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      rd    <= 3'd0;
    end else if (in_fire) begin
      count <= count_next;
      rd    <= 3'd0;
    end else if (out_fire) begin
      if (at_final) begin
        count <= 3'd0;
        rd    <= 3'd0;
      end else begin
        rd <= rd + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pieces     <= pieces_next;
      fin_has    <= fin_has_next;
      fin_last   <= fin_last_next;
      fin_status <= fin_status_next;
    end
  end

  `JSEU_ASSERT_NOW(a_status_only_last, out_valid && status != ERR_NONE, last, "status before last")
  `JSEU_ASSERT_NOW(a_bare_only_last, out_valid && !has_byte, last, "bare result that is not last")
  `JSEU_ASSERT_NEXT(a_end_clears, in_fire && string_end, string_cleared, "string state not cleared")
  `JSEU_ASSERT_NEXT(a_silent_after_utf8, utf8_drop, !out_valid, "output after invalid UTF-8")

endmodule
